// File: src/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the JSON string unescaper: status codes,
// UTF-8 lead and continuation constants, and the queue word passed from the
// front to the back.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Result status codes.
  localparam logic [2:0] ST_BYTE      = 3'd0;
  localparam logic [2:0] ST_CLOSED    = 3'd1;
  localparam logic [2:0] ST_UNTERM    = 3'd2;
  localparam logic [2:0] ST_OPEN_ESC  = 3'd3;
  localparam logic [2:0] ST_BAD_ESC   = 3'd4;
  localparam logic [2:0] ST_BAD_HEX   = 3'd5;
  localparam logic [2:0] ST_SHORT_HEX = 3'd6;
  localparam logic [2:0] ST_NO_QUOTE  = 3'd7;

  // UTF-8 encoding limits and marks.
  localparam logic [15:0] CP_ONE_MAX  = 16'h007F;
  localparam logic [15:0] CP_TWO_MAX  = 16'h07FF;
  localparam logic [7:0]  LEAD_TWO    = 8'hC0;
  localparam logic [7:0]  LEAD_THREE  = 8'hE0;
  localparam logic [7:0]  CONT_MARK   = 8'h80;
  localparam logic [7:0]  CONT_MASK   = 8'h3F;

  // One queue word: all results caused by one input byte.
  typedef struct packed {
    logic [1:0]       res_cnt;  // 1 to 3 results
    logic [2:0]       status;
    logic [2:0][7:0]  bytes;    // bytes[0] goes out first
  } entry_t;

endpackage

// File: src/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Parser front end. Tracks the literal mode and the partial \u code point,
// classifies each input word and pushes one queue word per input that causes
// results.
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  input  logic              input_end_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output jsu_pkg::entry_t   q_entry_o
);

  localparam logic [1:0] MODE_WAIT = 2'd0;
  localparam logic [1:0] MODE_STR  = 2'd1;
  localparam logic [1:0] MODE_ESC  = 2'd2;
  localparam logic [1:0] MODE_HEX  = 2'd3;

  logic [1:0]  mode_q, mode_d;
  logic [11:0] hex_acc_q, hex_acc_d;
  logic [1:0]  hex_cnt_q, hex_cnt_d;
  logic        accept;
  logic        digit_ok;
  logic [3:0]  digit;
  logic [15:0] code_pt;
  jsu_pkg::entry_t ent;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    digit_ok = 1'b1;
    digit    = 4'd0;
    if (in_byte_i >= "0" && in_byte_i <= "9") begin
      digit = 4'(in_byte_i - "0");
    end else if (in_byte_i >= "a" && in_byte_i <= "f") begin
      digit = 4'(in_byte_i - "a" + 8'd10);
    end else if (in_byte_i >= "A" && in_byte_i <= "F") begin
      digit = 4'(in_byte_i - "A" + 8'd10);
    end else begin
      digit_ok = 1'b0;
    end
  end

  assign code_pt = {hex_acc_q, digit};

  always_comb begin
    ent       = '0;
    ent.status = jsu_pkg::ST_BYTE;
    mode_d    = mode_q;
    hex_acc_d = hex_acc_q;
    hex_cnt_d = hex_cnt_q;
    if (input_end_i) begin
      ent.res_cnt = 2'd1;
      unique case (mode_q)
        MODE_STR: ent.status = jsu_pkg::ST_UNTERM;
        MODE_ESC: ent.status = jsu_pkg::ST_OPEN_ESC;
        MODE_HEX: ent.status = jsu_pkg::ST_SHORT_HEX;
        default:  ent.status = jsu_pkg::ST_NO_QUOTE;
      endcase
      mode_d    = MODE_WAIT;
      hex_acc_d = '0;
      hex_cnt_d = '0;
    end else begin
      unique case (mode_q)
        MODE_STR: begin
          if (in_byte_i == "\"") begin
            ent.res_cnt = 2'd1;
            ent.status  = jsu_pkg::ST_CLOSED;
            mode_d      = MODE_WAIT;
          end else if (in_byte_i == "\\") begin
            mode_d = MODE_ESC;
          end else begin
            ent.res_cnt  = 2'd1;
            ent.bytes[0] = in_byte_i;
          end
        end
        MODE_ESC: begin
          ent.res_cnt = 2'd1;
          mode_d      = MODE_STR;
          unique case (in_byte_i)
            "\"", "\\", "/": ent.bytes[0] = in_byte_i;
            "b":             ent.bytes[0] = 8'h08;
            "f":             ent.bytes[0] = 8'h0C;
            "n":             ent.bytes[0] = 8'h0A;
            "r":             ent.bytes[0] = 8'h0D;
            "t":             ent.bytes[0] = 8'h09;
            "u": begin
              ent.res_cnt = 2'd0;
              mode_d      = MODE_HEX;
              hex_acc_d   = '0;
              hex_cnt_d   = '0;
            end
            default: begin
              ent.status = jsu_pkg::ST_BAD_ESC;
              mode_d     = MODE_WAIT;
              hex_acc_d  = '0;
              hex_cnt_d  = '0;
            end
          endcase
        end
        MODE_HEX: begin
          if (!digit_ok) begin
            ent.res_cnt = 2'd1;
            ent.status  = jsu_pkg::ST_BAD_HEX;
            mode_d      = MODE_WAIT;
            hex_acc_d   = '0;
            hex_cnt_d   = '0;
          end else if (hex_cnt_q == 2'd3) begin
            // Fourth digit completes the code point; encode it as UTF-8.
            if (code_pt <= jsu_pkg::CP_ONE_MAX) begin
              ent.res_cnt  = 2'd1;
              ent.bytes[0] = code_pt[7:0];
            end else if (code_pt <= jsu_pkg::CP_TWO_MAX) begin
              ent.res_cnt  = 2'd2;
              ent.bytes[0] = jsu_pkg::LEAD_TWO | {3'd0, code_pt[10:6]};
              ent.bytes[1] = jsu_pkg::CONT_MARK | (code_pt[7:0] & jsu_pkg::CONT_MASK);
            end else begin
              ent.res_cnt  = 2'd3;
              ent.bytes[0] = jsu_pkg::LEAD_THREE | {4'd0, code_pt[15:12]};
              ent.bytes[1] = jsu_pkg::CONT_MARK | {2'd0, code_pt[11:6]};
              ent.bytes[2] = jsu_pkg::CONT_MARK | (code_pt[7:0] & jsu_pkg::CONT_MASK);
            end
            mode_d    = MODE_STR;
            hex_acc_d = '0;
            hex_cnt_d = '0;
          end else begin
            hex_acc_d = code_pt[11:0];
            hex_cnt_d = hex_cnt_q + 2'd1;
          end
        end
        default: begin
          if (in_byte_i == "\"") begin
            mode_d    = MODE_STR;
            hex_acc_d = '0;
            hex_cnt_d = '0;
          end else begin
            ent.res_cnt = 2'd1;
            ent.status  = jsu_pkg::ST_NO_QUOTE;
            hex_acc_d   = '0;
            hex_cnt_d   = '0;
          end
        end
      endcase
    end
  end

  assign q_push_o  = accept && (ent.res_cnt != 2'd0);
  assign q_entry_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_WAIT;
      hex_acc_q <= '0;
      hex_cnt_q <= '0;
    end else if (accept) begin
      mode_q    <= mode_d;
      hex_acc_q <= hex_acc_d;
      hex_cnt_q <= hex_cnt_d;
    end
  end

endmodule

// File: src/jsu_fifo.sv
// ----------------------------------------------------------------------------
// jsu_fifo
// Short queue of result words between the front and the back. The oldest
// word sits in a head register; the words behind it wait in a small memory.
// ----------------------------------------------------------------------------
module jsu_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  jsu_pkg::entry_t  push_entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output jsu_pkg::entry_t  head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  jsu_pkg::entry_t mem_q [Depth];
  jsu_pkg::entry_t head_q;
  logic            head_vld_q;
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop, to_head, refill, mem_push;

  assign full_o   = head_vld_q && (cnt_q == CntW'(Depth));
  assign empty_o  = !head_vld_q;
  assign head_o   = head_q;
  assign do_push  = push_i && !full_o;
  assign do_pop   = pop_i && head_vld_q;
  // A new word goes straight to the head when nothing older is left behind it.
  assign to_head  = do_push && (!head_vld_q || (do_pop && (cnt_q == '0)));
  assign refill   = do_pop && (cnt_q != '0);
  assign mem_push = do_push && !to_head;

  always_ff @(posedge clk_i) begin
    if (mem_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
    if (to_head) begin
      head_q <= push_entry_i;
    end else if (refill) begin
      head_q <= mem_q[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      cnt_q      <= '0;
    end else begin
      head_vld_q <= (head_vld_q && !do_pop) || to_head || refill;
      if (mem_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (refill) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (mem_push && !refill) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!mem_push && refill) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: src/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Result serializer. Sends the one to three results of the head queue word one
// per cycle when not stalled via an output register and marks the last one.
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  jsu_pkg::entry_t  q_head_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic [2:0]       status_o,
  output logic             run_last_o
);

  logic       out_valid_q;
  logic [7:0] byte_q, byte_d;
  logic [2:0] status_q;
  logic       last_q, last_d;
  logic [1:0] idx_q;
  logic       load;

  assign load = !out_valid_q || out_ready_i;

  always_comb begin
    unique case (idx_q)
      2'd0:    byte_d = q_head_i.bytes[0];
      2'd1:    byte_d = q_head_i.bytes[1];
      2'd2:    byte_d = q_head_i.bytes[2];
      default: byte_d = '0;
    endcase
  end

  assign last_d  = (idx_q == (q_head_i.res_cnt - 2'd1));
  assign q_pop_o = load && !q_empty_i && last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (load) begin
      out_valid_q <= !q_empty_i;
      if (!q_empty_i) begin
        idx_q <= last_d ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && !q_empty_i) begin
      byte_q   <= byte_d;
      status_q <= q_head_i.status;
      last_q   <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = byte_q;
  assign status_o    = status_q;
  assign run_last_o  = last_q;

endmodule

// File: src/json_string_unescape_utf8_top.sv
// Path: a result goes through the queue head register and then the output register.
// Throughput: one input word per cycle while the queue has room; the output side sends one
// result per cycle while out_ready_i is high; a \u escape of N bytes takes N result slots.
// The queue of FifoDepth + 1 words lets the front keep accepting while the back drains.
// Reset (rst_ni low, asynchronous): waits for an opening quote, queue and output empty.
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_top
// JSON string literal unescaper with UTF-8 output for \u escapes.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_top #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       input_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [2:0] status_o,
  output logic       run_last_o
);

  logic            q_full, q_empty, q_push, q_pop;
  jsu_pkg::entry_t q_in, q_head;

  jsu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .input_end_i (input_end_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (q_in)
  );

  jsu_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_in),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .empty_o      (q_empty),
    .head_o       (q_head)
  );

  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .status_o    (status_o),
    .run_last_o  (run_last_o)
  );

endmodule

// File: src/jsu_checker.sv
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks for the JSON string unescaper, bound to the top level.
// ----------------------------------------------------------------------------
module jsu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic [2:0] status_o,
  input logic       run_last_o
);

  // A stalled result word keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) &&
      $stable(status_o) && $stable(run_last_o))
    else $error("output word changed while stalled");

  // Errors and the closing quote carry a zero byte.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != jsu_pkg::ST_BYTE |-> out_byte_o == 8'h00)
    else $error("non-byte status with nonzero byte");

  // Only UTF-8 sequences span several words, so a status is always alone.
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != jsu_pkg::ST_BYTE |-> run_last_o)
    else $error("status word not marked last");

  // The rest of a multi-byte sequence follows with no gap.
  a_seq_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !run_last_o |=>
      out_valid_o && status_o == jsu_pkg::ST_BYTE && out_byte_o[7:6] == 2'b10)
    else $error("multi-byte sequence broken");

endmodule

bind json_string_unescape_utf8_top jsu_checker u_jsu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_byte_o  (out_byte_o),
  .status_o    (status_o),
  .run_last_o  (run_last_o)
);

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the JSON string unescaper. A short table of
// directed words covers the byte extremes, a three-byte \u escape and every
// error path. Random literals follow, mostly well formed, with noise and broken
// escapes mixed in. Results are checked against a local decoder or typed rows.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned RandWords  = 230;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;

  typedef enum logic [2:0] {
    M_WAIT = 3'd0,
    M_STR  = 3'd1,
    M_ESC  = 3'd2,
    M_HEX  = 3'd3
  } lit_mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] st;
    logic       last;
  } dec_res_t;

  typedef struct packed {
    logic [7:0] b;
    logic       e;
    logic       typed;
    logic [2:0] st;
    logic [7:0] d;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic       run_last;

  // Decoder state, mirrors the block after reset.
  lit_mode_e   lit_mode = M_WAIT;
  logic [15:0] hex_acc = 16'h0000;
  logic [1:0]  hex_cnt = 2'd0;

  dec_res_t step_res[$];
  dec_res_t exp_q[$];

  int unsigned errors = 0;
  int unsigned words_sent = 0;
  int unsigned cycles = 0;
  int unsigned snd_run = 0;
  int unsigned rcv_hold = 0;
  int unsigned rcv_run = 0;
  logic        long_hold_req = 1'b0;

  logic [7:0] esc_chars [8] = '{8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74};

  dir_row_t dir_tab [29] = '{
    '{8'h61, 1'b0, 1'b1, jsu_pkg::ST_NO_QUOTE,  8'h00},
    '{8'h3B, 1'b1, 1'b1, jsu_pkg::ST_NO_QUOTE,  8'h00},
    '{8'h22, 1'b0, 1'b0, jsu_pkg::ST_BYTE,      8'h00},
    '{8'hFF, 1'b0, 1'b1, jsu_pkg::ST_BYTE,      8'hFF},
    '{8'h00, 1'b0, 1'b1, jsu_pkg::ST_BYTE,      8'h00},
    '{8'h5C, 1'b0, 1'b0, jsu_pkg::ST_BYTE,      8'h00},
    '{8'h75, 1'b0, 1'b0, jsu_pkg::ST_BYTE,      8'h00},
    '{8'h46, 1'b0, 1'b0, jsu_pkg::ST_BYTE,      8'h00},
    '{8'h66, 1'b0, 1'b0, jsu_pkg::ST_BYTE,      8'h00},
    '{8'h46, 1'b0, 1'b0, jsu_pkg::ST_BYTE,      8'h00},
    '{8'h66, 1'b0, 1'b0, jsu_pkg::ST_BYTE,      8'h00},
    '{8'h22, 1'b0, 1'b1, jsu_pkg::ST_CLOSED,    8'h00},
    '{8'h22, 1'b0, 1'b0, jsu_pkg::ST_BYTE,      8'h00},
    '{8'hA5, 1'b1, 1'b1, jsu_pkg::ST_UNTERM,    8'h00},
    '{8'h22, 1'b0, 1'b0, jsu_pkg::ST_BYTE,      8'h00},
    '{8'h5C, 1'b0, 1'b0, jsu_pkg::ST_BYTE,      8'h00},
    '{8'h71, 1'b0, 1'b1, jsu_pkg::ST_BAD_ESC,   8'h00},
    '{8'h22, 1'b0, 1'b0, jsu_pkg::ST_BYTE,      8'h00},
    '{8'h5C, 1'b0, 1'b0, jsu_pkg::ST_BYTE,      8'h00},
    '{8'h00, 1'b1, 1'b1, jsu_pkg::ST_OPEN_ESC,  8'h00},
    '{8'h22, 1'b0, 1'b0, jsu_pkg::ST_BYTE,      8'h00},
    '{8'h5C, 1'b0, 1'b0, jsu_pkg::ST_BYTE,      8'h00},
    '{8'h75, 1'b0, 1'b0, jsu_pkg::ST_BYTE,      8'h00},
    '{8'h47, 1'b0, 1'b1, jsu_pkg::ST_BAD_HEX,   8'h00},
    '{8'h22, 1'b0, 1'b0, jsu_pkg::ST_BYTE,      8'h00},
    '{8'h5C, 1'b0, 1'b0, jsu_pkg::ST_BYTE,      8'h00},
    '{8'h75, 1'b0, 1'b0, jsu_pkg::ST_BYTE,      8'h00},
    '{8'h37, 1'b0, 1'b0, jsu_pkg::ST_BYTE,      8'h00},
    '{8'hFF, 1'b1, 1'b1, jsu_pkg::ST_SHORT_HEX, 8'h00}
  };

  json_string_unescape_utf8_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_byte_i   (in_byte),
    .input_end_i (in_end),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_byte_o  (out_byte),
    .status_o    (status),
    .run_last_o  (run_last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Bit 4 flags a valid hex digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h61 + 8'd10)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h41 + 8'd10)};
    return 5'd0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return (($urandom_range(0, 1) == 0) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  function automatic void reset_literal();
    lit_mode = M_WAIT;
    hex_acc  = 16'h0000;
    hex_cnt  = 2'd0;
  endfunction

  // Appends one result to the results of the current word.
  function automatic void add_res(input logic [7:0] data, input logic [2:0] st);
    dec_res_t r;
    r.data   = data;
    r.st     = st;
    r.last   = 1'b0;
    step_res = {step_res, r};
  endfunction

  // Decodes one word and leaves the results it causes in step_res.
  function automatic void decode_byte(input logic [7:0] c, input logic e);
    logic [4:0]  hv;
    logic [15:0] cp;
    step_res.delete();
    if (e) begin
      case (lit_mode)
        M_STR:   add_res(8'h00, jsu_pkg::ST_UNTERM);
        M_ESC:   add_res(8'h00, jsu_pkg::ST_OPEN_ESC);
        M_HEX:   add_res(8'h00, jsu_pkg::ST_SHORT_HEX);
        default: add_res(8'h00, jsu_pkg::ST_NO_QUOTE);
      endcase
      reset_literal();
    end else if (lit_mode == M_STR) begin
      if (c == CH_QUOTE) begin
        add_res(8'h00, jsu_pkg::ST_CLOSED);
        reset_literal();
      end else if (c == CH_BSLASH) begin
        lit_mode = M_ESC;
      end else begin
        add_res(c, jsu_pkg::ST_BYTE);
      end
    end else if (lit_mode == M_ESC) begin
      lit_mode = M_STR;
      case (c)
        8'h22, 8'h5C, 8'h2F: add_res(c, jsu_pkg::ST_BYTE);
        8'h62: add_res(8'h08, jsu_pkg::ST_BYTE);
        8'h66: add_res(8'h0C, jsu_pkg::ST_BYTE);
        8'h6E: add_res(8'h0A, jsu_pkg::ST_BYTE);
        8'h72: add_res(8'h0D, jsu_pkg::ST_BYTE);
        8'h74: add_res(8'h09, jsu_pkg::ST_BYTE);
        CH_U: begin
          lit_mode = M_HEX;
          hex_acc  = 16'h0000;
          hex_cnt  = 2'd0;
        end
        default: begin
          add_res(8'h00, jsu_pkg::ST_BAD_ESC);
          reset_literal();
        end
      endcase
    end else if (lit_mode == M_HEX) begin
      hv = hex_val(c);
      if (!hv[4]) begin
        add_res(8'h00, jsu_pkg::ST_BAD_HEX);
        reset_literal();
      end else begin
        hex_acc = {hex_acc[11:0], hv[3:0]};
        if (hex_cnt == 2'd3) begin
          cp = hex_acc;
          if (cp <= jsu_pkg::CP_ONE_MAX) begin
            add_res(cp[7:0], jsu_pkg::ST_BYTE);
          end else if (cp <= jsu_pkg::CP_TWO_MAX) begin
            add_res(jsu_pkg::LEAD_TWO | {3'b000, cp[10:6]}, jsu_pkg::ST_BYTE);
            add_res(jsu_pkg::CONT_MARK | (cp[7:0] & jsu_pkg::CONT_MASK), jsu_pkg::ST_BYTE);
          end else begin
            add_res(jsu_pkg::LEAD_THREE | {4'b0000, cp[15:12]}, jsu_pkg::ST_BYTE);
            add_res(jsu_pkg::CONT_MARK | {2'b00, cp[11:6]}, jsu_pkg::ST_BYTE);
            add_res(jsu_pkg::CONT_MARK | {2'b00, cp[5:0]}, jsu_pkg::ST_BYTE);
          end
          lit_mode = M_STR;
          hex_acc  = 16'h0000;
          hex_cnt  = 2'd0;
        end else begin
          hex_cnt = hex_cnt + 2'd1;
        end
      end
    end else begin
      // Unused mode values behave as waiting.
      if (c == CH_QUOTE) begin
        lit_mode = M_STR;
        hex_acc  = 16'h0000;
        hex_cnt  = 2'd0;
      end else begin
        add_res(8'h00, jsu_pkg::ST_NO_QUOTE);
        reset_literal();
      end
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
  endfunction

  function automatic int unsigned sender_gap();
    int unsigned r;
    if (snd_run > 0) begin
      snd_run--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      snd_run = $urandom_range(10, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic flag_mismatch(input string what);
    $display("ERROR at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  // Offers one word, holds it until accepted, then idles for a random gap.
  task automatic send_word(input logic [7:0] b, input logic e, input logic typed,
                           input logic [2:0] st, input logic [7:0] d);
    int unsigned gap;
    decode_byte(b, e);
    if (typed) begin
      step_res.delete();
      add_res(d, st);
      step_res[0].last = 1'b1;
    end
    foreach (step_res[i]) exp_q = {exp_q, step_res[i]};
    in_valid <= 1'b1;
    in_byte  <= b;
    in_end   <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send(input logic [7:0] b, input logic e);
    send_word(b, e, 1'b0, jsu_pkg::ST_BYTE, 8'h00);
  endtask

  task automatic send_hex_digits(input logic [15:0] cp, input int unsigned n);
    for (int i = 0; i < n; i++) send(hex_char(cp[15 - 4 * i -: 4]), 1'b0);
  endtask

  // One random literal: mostly well formed, sometimes broken part way.
  task automatic gen_literal();
    int unsigned n;
    int unsigned kind;
    logic [7:0]  b;
    logic [4:0]  hv;
    logic [15:0] cp;
    logic        alive;
    alive = 1'b1;
    send(CH_QUOTE, 1'b0);
    n = $urandom_range(0, 8);
    for (int i = 0; i < n && alive; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        b = 8'($urandom_range(0, 255));
        if (b == CH_QUOTE || b == CH_BSLASH) b = 8'($urandom_range(0, 8'h21));
        send(b, 1'b0);
      end else if (kind < 70) begin
        send(CH_BSLASH, 1'b0);
        send(esc_chars[3'($urandom_range(0, 7))], 1'b0);
      end else if (kind < 92) begin
        case ($urandom_range(0, 3))
          0:       cp = 16'($urandom_range(0, 16'h007F));
          1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
          default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
        endcase
        send(CH_BSLASH, 1'b0);
        send(CH_U, 1'b0);
        send_hex_digits(cp, 4);
      end else begin
        alive = 1'b0;
        cp = 16'($urandom_range(0, 16'hFFFF));
        case ($urandom_range(0, 3))
          0: begin
            // Escape letter picked from the whole byte range.
            send(CH_BSLASH, 1'b0);
            send(8'($urandom_range(0, 255)), 1'b0);
            alive = (lit_mode == M_STR);
          end
          1: begin
            send(CH_BSLASH, 1'b0);
            send(CH_U, 1'b0);
            send_hex_digits(cp, $urandom_range(0, 3));
            b  = 8'($urandom_range(0, 255));
            hv = hex_val(b);
            if (hv[4]) b = 8'h7A;
            send(b, 1'b0);
          end
          2: begin
            send(CH_BSLASH, 1'b0);
            send(CH_U, 1'b0);
            send_hex_digits(cp, $urandom_range(0, 3));
            send(8'($urandom_range(0, 255)), 1'b1);
          end
          default: begin
            send(CH_BSLASH, 1'b0);
            send(8'($urandom_range(0, 255)), 1'b1);
          end
        endcase
      end
    end
    if (alive) begin
      if ($urandom_range(0, 9) != 0) send(CH_QUOTE, 1'b0);
      else send(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  // Receiver side: random holds and bursts, plus one long hold on request.
  initial begin : rcv_proc
    int unsigned r;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rcv_hold = 150;
        rcv_run  = 0;
      end
      if (rcv_hold > 0) begin
        rcv_hold--;
        out_ready <= 1'b0;
      end else if (rcv_run > 0) begin
        rcv_run--;
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 30) begin
          rcv_hold = $urandom_range(0, 2);
          out_ready <= 1'b0;
        end else if (r < 34) begin
          rcv_hold = $urandom_range(15, 40);
          out_ready <= 1'b0;
        end else if (r < 40) begin
          rcv_run = $urandom_range(30, 60);
          out_ready <= 1'b1;
        end else begin
          rcv_run = $urandom_range(0, 6);
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Every accepted result word is matched against the oldest expectation.
  always @(posedge clk) begin : out_mon
    dec_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (exp_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result byte %02h status %0d run_last %0b",
                                out_byte, status, run_last));
      end else begin
        want = exp_q.pop_front();
        if (out_byte !== want.data || status !== want.st || run_last !== want.last) begin
          flag_mismatch($sformatf("got byte %02h status %0d run_last %0b, want %02h %0d %0b",
                                  out_byte, status, run_last,
                                  want.data, want.st, want.last));
        end
      end
    end
  end

  initial begin : watchdog
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stim
    logic hold_done;
    logic pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      send_word(dir_tab[i].b, dir_tab[i].e, dir_tab[i].typed, dir_tab[i].st, dir_tab[i].d);
    end

    while (words_sent < $size(dir_tab) + RandWords) begin
      if (!hold_done && words_sent >= 90) begin
        // The sender keeps offering words while the output is held off.
        long_hold_req = 1'b1;
        hold_done = 1'b1;
      end
      if (!pause_done && words_sent >= 190) begin
        pause_done = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (exp_q.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 99) < 85) begin
        gen_literal();
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send(8'($urandom_range(0, 255)), ($urandom_range(0, 9) == 0));
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (exp_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
